>>> rtl/chm_pkg.sv
package chm_pkg;

  localparam int unsigned HashBitsDef = 8;
  localparam int unsigned CapacityDef = 256;

  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncAdd    = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StHead,
    StHeadWait,
    StWalk,
    StUnlink,
    StFree,
    StAlloc,
    StOut
  } state_e;

endpackage

>>> rtl/chained_hash_map.sv
// An accepted transaction reads its bucket head, then walks the chain, reading
// and comparing one entry at a time; a walk that ends without a match takes
// one more step, as does a remove that hits or an add of a new key; an unused
// code answers directly. Throughput: one transaction in flight; the next is
// taken in the cycle after the result is accepted. Reset: asynchronous, active
// low; a clearing pass then empties every bucket head, one a cycle, before input.
module chained_hash_map #(
  parameter int unsigned HASH_BITS = chm_pkg::HashBitsDef,
  parameter int unsigned CAPACITY  = chm_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               found_o,
  output logic               status_o
);

  localparam int unsigned NBuckets = 1 << HASH_BITS;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PtrW     = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] Nil  = PtrW'(CAPACITY);
  localparam logic [PtrW-1:0] Cap  = PtrW'(CAPACITY);

  // Memories
  logic [PtrW-1:0] head_mem [NBuckets];
  logic [31:0]     key_mem  [CAPACITY];
  logic [31:0]     val_mem  [CAPACITY];
  logic [PtrW-1:0] link_mem [CAPACITY];
  logic [IdxW-1:0] free_mem [CAPACITY];

  chm_pkg::state_e state_q, state_d;

  logic [HASH_BITS-1:0] clr_q, clr_d;
  logic [1:0]           func_q, func_d;
  logic [31:0]          key_q, key_d, val_q, val_d;
  logic [PtrW-1:0]      cur_q, cur_d, prev_q, prev_d, used_q, used_d;
  logic [PtrW-1:0]      steps_q, steps_d;
  logic [PtrW-1:0]      hwm_q, hwm_d;
  logic                 fresh_q, fresh_d;
  logic [31:0]          rv_q, rv_d;
  logic                 found_q, found_d, status_q, status_d;

  // Registered read data
  logic [PtrW-1:0] head_rd_q, link_rd_q;
  logic [31:0]     key_rd_q, val_rd_q;
  logic [IdxW-1:0] free_rd_q;

  logic [HASH_BITS-1:0] bkt;
  assign bkt = key_q[HASH_BITS-1:0];

  // Write controls
  logic            hd_we, key_we, val_we, lk_we, fr_we;
  logic [HASH_BITS-1:0] hd_wa;
  logic [PtrW-1:0] hd_wd, lk_wd;
  logic [IdxW-1:0] ent_wa, lk_wa, fr_wa, fr_wd;
  logic [31:0]     val_wd;
  logic [IdxW-1:0] rd_idx, fr_ra;
  logic [HASH_BITS-1:0] hd_ra;

  // Free stack: a slot at or above the high-water mark of the fill count has
  // never been written back, so the fill count itself is used as the index
  logic [IdxW-1:0] alloc_idx;
  assign alloc_idx = (used_q < hwm_q) ? free_rd_q : used_q[IdxW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chm_pkg::StClear: if (clr_q == HASH_BITS'(NBuckets - 1)) state_d = chm_pkg::StIdle;
      chm_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (func_i != chm_pkg::FuncUnused) ? chm_pkg::StHead : chm_pkg::StOut;
        end
      end
      chm_pkg::StHead:     state_d = chm_pkg::StHeadWait;
      chm_pkg::StHeadWait: state_d = chm_pkg::StWalk;
      chm_pkg::StWalk: begin
        if (fresh_q) begin
          if (cur_q >= Nil || steps_q >= Cap) begin
            state_d = (func_q == chm_pkg::FuncAdd && used_q < Cap) ?
                      chm_pkg::StAlloc : chm_pkg::StOut;
          end else begin
            state_d = chm_pkg::StWalk;
          end
        end else if (key_rd_q == key_q) begin
          state_d = (func_q == chm_pkg::FuncRemove) ? chm_pkg::StUnlink : chm_pkg::StOut;
        end
      end
      chm_pkg::StUnlink: state_d = chm_pkg::StOut;
      chm_pkg::StAlloc:  state_d = chm_pkg::StOut;
      chm_pkg::StOut:    if (out_ready_i) state_d = chm_pkg::StIdle;
      default:           state_d = chm_pkg::StIdle;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_d = clr_q; func_d = func_q; key_d = key_q; val_d = val_q;
    cur_d = cur_q; prev_d = prev_q; used_d = used_q; steps_d = steps_q;
    hwm_d = hwm_q;
    fresh_d = 1'b0; rv_d = rv_q; found_d = found_q; status_d = status_q;
    hd_we = 1'b0; hd_wa = bkt; hd_wd = Nil;
    key_we = 1'b0; val_we = 1'b0; val_wd = val_q; ent_wa = alloc_idx;
    lk_we = 1'b0; lk_wa = cur_q[IdxW-1:0]; lk_wd = Nil;
    fr_we = 1'b0; fr_wa = '0; fr_wd = cur_q[IdxW-1:0];
    rd_idx = cur_q[IdxW-1:0]; hd_ra = bkt; fr_ra = used_q[IdxW-1:0];
    case (state_q)
      chm_pkg::StClear: begin
        hd_we = 1'b1; hd_wa = clr_q; hd_wd = Nil;
        clr_d = clr_q + 1'b1;
      end
      chm_pkg::StIdle: begin
        if (in_valid_i) begin
          func_d = func_i; key_d = key_i; val_d = value_i;
          rv_d = '0; found_d = 1'b0; status_d = 1'b0;
          prev_d = Nil; steps_d = '0;
        end
      end
      chm_pkg::StHead: hd_ra = bkt;
      chm_pkg::StHeadWait: begin
        cur_d = head_rd_q; fresh_d = 1'b1;
      end
      chm_pkg::StWalk: begin
        if (fresh_q) begin
          // Issue reads for the current entry, or finish on end of chain or step limit
          if (cur_q >= Nil || steps_q >= Cap) begin
            if (func_q == chm_pkg::FuncAdd && used_q >= Cap) status_d = 1'b1;
          end
        end else if (key_rd_q == key_q) begin
          found_d = 1'b1;
          case (func_q)
            chm_pkg::FuncLookup: rv_d = val_rd_q;
            chm_pkg::FuncAdd: begin
              val_we = 1'b1; ent_wa = cur_q[IdxW-1:0]; val_wd = val_q;
            end
            default: ;
          endcase
        end else begin
          prev_d = cur_q; cur_d = link_rd_q; steps_d = steps_q + 1'b1;
          fresh_d = 1'b1;
        end
      end
      chm_pkg::StUnlink: begin
        if (prev_q < Nil) begin
          lk_we = 1'b1; lk_wa = prev_q[IdxW-1:0]; lk_wd = link_rd_q;
        end else begin
          hd_we = 1'b1; hd_wd = link_rd_q;
        end
        if (used_q > '0) begin
          used_d = used_q - 1'b1;
          fr_we = 1'b1; fr_wa = IdxW'(used_q - 1'b1); fr_wd = cur_q[IdxW-1:0];
        end
      end
      chm_pkg::StAlloc: begin
        key_we = 1'b1; val_we = 1'b1; val_wd = val_q; ent_wa = alloc_idx;
        lk_we = 1'b1; lk_wa = alloc_idx; lk_wd = head_rd_q;
        hd_we = 1'b1; hd_wd = PtrW'(alloc_idx);
        used_d = used_q + 1'b1;
        if (used_q == hwm_q) hwm_d = hwm_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (key_we) key_mem[ent_wa] <= key_q;
    if (val_we) val_mem[ent_wa] <= val_wd;
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (fr_we) free_mem[fr_wa] <= fr_wd;
    head_rd_q <= head_mem[hd_ra];
    key_rd_q  <= key_mem[rd_idx];
    val_rd_q  <= val_mem[rd_idx];
    link_rd_q <= link_mem[rd_idx];
    free_rd_q <= free_mem[fr_ra];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chm_pkg::StClear; clr_q <= '0; used_q <= '0; fresh_q <= 1'b0;
      hwm_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; used_q <= used_d; fresh_q <= fresh_d;
      hwm_q <= hwm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; key_q <= key_d; val_q <= val_d; cur_q <= cur_d;
    prev_q <= prev_d; steps_q <= steps_d; rv_q <= rv_d;
    found_q <= found_d; status_q <= status_d;
  end

  assign in_ready_o     = (state_q == chm_pkg::StIdle);
  assign out_valid_o    = (state_q == chm_pkg::StOut);
  assign result_value_o = rv_q;
  assign found_o        = found_q;
  assign status_o       = status_q;

endmodule
